>>> design/http_body_dechunker_core_defines.svh
// ----------------------------------------------------------------------------
// http_body_dechunker_core_defines
// Assertion macros shared by the dechunker modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef HTTP_BODY_DECHUNKER_CORE_DEFINES_SVH
`define HTTP_BODY_DECHUNKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge of aclk out of reset.
`define DBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define DBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DBC_ASSERT_IMP(lbl, ante, cons, msg)
`define DBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg
// Types, codes and constants of the HTTP body dechunker.
// ----------------------------------------------------------------------------
package dbc_pkg;

    // Widest hex chunk size accepted before an overflow is flagged.
    localparam int SIZE_BITS   = 32;
    localparam int LENGTH_W    = 32;
    // Counter holds either a hex size or a fixed body length.
    localparam int CNT_W       = (SIZE_BITS > LENGTH_W) ? SIZE_BITS : LENGTH_W;
    localparam int DATA_W      = 8;
    localparam int HEX_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BODY_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] CHAR_CR = 8'd13;
    localparam logic [DATA_W-1:0] CHAR_LF = 8'd10;

    typedef enum logic [3:0] {
        PH_HEX,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_LAST_CR,
        PH_LAST_LF,
        PH_LAST_END,
        PH_FIXED,
        PH_FINAL
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_DONE  = 3'd1,
        ST_CRLF  = 3'd2,
        ST_HEX   = 3'd3,
        ST_LAST  = 3'd4,
        ST_TRUNC = 3'd5,
        ST_OVF   = 3'd6
    } status_t;

    // Classified input word as it sits in the queue.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              stream_end;
        logic              is_hex;
        logic [HEX_W-1:0]  hex_val;
        logic              is_cr;
        logic              is_lf;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [DATA_W-1:0] body_byte;
        logic              body_valid;
        status_t           status;
        logic              finished;
    } result_t;

endpackage

>>> design/http_body_dechunker_core.sv
// ----------------------------------------------------------------------------
// http_body_dechunker_core
// HTTP message body decoder: fixed content length or chunked transfer coding.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          tdata          tuser
//  s_        in   s_tvalid/tready    data_byte      - (tlast = stream_end)
//  m_        out  m_tvalid/tready    body_byte      body_valid, status, finished
//  cfg_      in   cfg_we             cfg_wdata      - (cfg_index selects register)
//
//  One word per clock sustained while m_tready holds high: each input word yields
//  exactly one result word. From input accept to result valid: classify into a
//  two-entry queue at the accept edge, then one pass of the decode state
//  machine into the output register, which frees as soon as its word is taken.
//  Reset (aresetn low, synchronous) selects chunked mode, zero length.
//  A stalled m_tready fills the queue and then drops s_tready; no word is lost.
// ----------------------------------------------------------------------------
module http_body_dechunker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,    // [7:0] data_byte
    input  logic                           s_tlast,    // stream_end
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,    // [7:0] body_byte
    output logic [4:0]                     m_tuser,    // [0] body_valid, [3:1] status,
                                                       // [4] finished
    // register writes
    input  logic                           cfg_we,
    input  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    dbc_pkg::item_t   wr_item;
    dbc_pkg::item_t   rd_item;
    dbc_pkg::result_t res;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    // Classify incoming bytes; hold off the source when the queue is full
    dbc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .item     (wr_item)
    );

    // Decouple the front from the decoder so each side stalls on its own
    dbc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (wr_item),
        .full    (q_full),
        .pop     (pop),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    // Advance the phase machine one word per pop and register the result
    dbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .empty     (q_empty),
        .rd_item   (rd_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = res.body_byte;
    assign m_tuser = {res.finished, res.status, res.body_valid};

endmodule

>>> design/dbc_front.sv
// ----------------------------------------------------------------------------
// dbc_front
// Input side: accept words while the queue has room and classify each byte.
// ----------------------------------------------------------------------------
module dbc_front (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dbc_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tlast,
    input  logic                       q_full,
    output logic                       push,
    output dbc_pkg::item_t             item
);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        item            = '0;
        item.data       = s_tdata;
        item.stream_end = s_tlast;
        item.is_cr      = (s_tdata == dbc_pkg::CHAR_CR);
        item.is_lf      = (s_tdata == dbc_pkg::CHAR_LF);
        // Decode the hex digit value; letters of either case
        if (s_tdata inside {[8'h30:8'h39]}) begin
            item.is_hex  = 1'b1;
            item.hex_val = dbc_pkg::HEX_W'(s_tdata - 8'h30);
        end else if (s_tdata inside {[8'h61:8'h66]}) begin
            item.is_hex  = 1'b1;
            item.hex_val = dbc_pkg::HEX_W'(s_tdata - 8'h57);
        end else if (s_tdata inside {[8'h41:8'h46]}) begin
            item.is_hex  = 1'b1;
            item.hex_val = dbc_pkg::HEX_W'(s_tdata - 8'h37);
        end
    end

endmodule

>>> design/dbc_queue.sv
// ----------------------------------------------------------------------------
// dbc_queue
// Short FIFO of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module dbc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dbc_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output dbc_pkg::item_t rd_item,
    output logic           empty
);

    dbc_pkg::item_t                   entry_reg [dbc_pkg::QUEUE_DEPTH];
    logic [dbc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dbc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dbc_pkg::QCNT_W-1:0]       count_reg,  count_next;

    localparam logic [dbc_pkg::QPTR_W-1:0] LAST_PTR = dbc_pkg::QPTR_W'(dbc_pkg::QUEUE_DEPTH - 1);
    localparam logic [dbc_pkg::QCNT_W-1:0] FULL_CNT = dbc_pkg::QCNT_W'(dbc_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> design/dbc_back.sv
// ----------------------------------------------------------------------------
// dbc_back
// Decode state machine and output register; holds the configuration.
// ----------------------------------------------------------------------------
`include "http_body_dechunker_core_defines.svh"

module dbc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           empty,
    input  dbc_pkg::item_t                 rd_item,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dbc_pkg::result_t               out_res
);

    logic                          body_mode_reg,   body_mode_next;
    logic [dbc_pkg::LENGTH_W-1:0]  body_length_reg, body_length_next;
    dbc_pkg::phase_t               phase_reg,       phase_next;
    logic [dbc_pkg::CNT_W-1:0]     chunk_reg,       chunk_next;
    logic                          seen_reg,        seen_next;
    dbc_pkg::status_t              status_reg,      status_next;
    logic                          out_valid_reg,   out_valid_next;
    dbc_pkg::result_t              out_res_reg,     res_next;
    logic                          cfg_hit;

    localparam logic [dbc_pkg::CNT_W-1:0] CNT_ONE = dbc_pkg::CNT_W'(1);

    assign pop       = !empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign cfg_hit   = cfg_we && ((cfg_index == dbc_pkg::CFG_BODY_MODE) ||
                                  (cfg_index == dbc_pkg::CFG_BODY_LENGTH));

    always_comb begin
        body_mode_next   = body_mode_reg;
        body_length_next = body_length_reg;
        phase_next       = phase_reg;
        chunk_next       = chunk_reg;
        seen_next        = seen_reg;
        status_next      = status_reg;
        res_next         = '0;

        if (pop) begin
            // Zero fixed length completes before the word is looked at
            if (phase_reg == dbc_pkg::PH_FIXED && chunk_reg == '0) begin
                phase_next  = dbc_pkg::PH_FINAL;
                status_next = dbc_pkg::ST_DONE;
            end
            if (phase_next != dbc_pkg::PH_FINAL) begin
                if (rd_item.stream_end) begin
                    phase_next = dbc_pkg::PH_FINAL;
                    if (phase_reg == dbc_pkg::PH_LAST_END) begin
                        status_next = dbc_pkg::ST_DONE;
                    end else if (phase_reg == dbc_pkg::PH_LAST_CR ||
                                 phase_reg == dbc_pkg::PH_LAST_LF) begin
                        status_next = dbc_pkg::ST_LAST;
                    end else begin
                        status_next = dbc_pkg::ST_TRUNC;
                    end
                end else begin
                    case (phase_reg)
                        dbc_pkg::PH_FIXED: begin
                            res_next.body_byte  = rd_item.data;
                            res_next.body_valid = 1'b1;
                            chunk_next          = chunk_reg - CNT_ONE;
                            if (chunk_reg == CNT_ONE) begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_DONE;
                            end
                        end
                        dbc_pkg::PH_HEX: begin
                            if (rd_item.is_hex) begin
                                if (chunk_reg[dbc_pkg::CNT_W-1:dbc_pkg::SIZE_BITS-4] != '0) begin
                                    phase_next  = dbc_pkg::PH_FINAL;
                                    status_next = dbc_pkg::ST_OVF;
                                end else begin
                                    chunk_next = {chunk_reg[dbc_pkg::CNT_W-5:0], rd_item.hex_val};
                                    seen_next  = 1'b1;
                                end
                            end else if (!seen_reg) begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_HEX;
                            end else if (rd_item.is_cr) begin
                                phase_next = dbc_pkg::PH_SIZE_LF;
                            end else begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_CRLF;
                            end
                        end
                        dbc_pkg::PH_SIZE_LF: begin
                            if (!rd_item.is_lf) begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_CRLF;
                            end else if (chunk_reg == '0) begin
                                phase_next = dbc_pkg::PH_LAST_CR;
                            end else begin
                                phase_next = dbc_pkg::PH_DATA;
                            end
                        end
                        dbc_pkg::PH_DATA: begin
                            res_next.body_byte  = rd_item.data;
                            res_next.body_valid = 1'b1;
                            chunk_next          = chunk_reg - CNT_ONE;
                            if (chunk_reg == CNT_ONE) begin
                                phase_next = dbc_pkg::PH_DATA_CR;
                            end
                        end
                        dbc_pkg::PH_DATA_CR: begin
                            if (rd_item.is_cr) begin
                                phase_next = dbc_pkg::PH_DATA_LF;
                            end else begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_CRLF;
                            end
                        end
                        dbc_pkg::PH_DATA_LF: begin
                            if (rd_item.is_lf) begin
                                phase_next = dbc_pkg::PH_HEX;
                                seen_next  = 1'b0;
                                chunk_next = '0;
                            end else begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_CRLF;
                            end
                        end
                        dbc_pkg::PH_LAST_CR: begin
                            if (rd_item.is_cr) begin
                                phase_next = dbc_pkg::PH_LAST_LF;
                            end else begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_LAST;
                            end
                        end
                        dbc_pkg::PH_LAST_LF: begin
                            if (rd_item.is_lf) begin
                                phase_next = dbc_pkg::PH_LAST_END;
                            end else begin
                                phase_next  = dbc_pkg::PH_FINAL;
                                status_next = dbc_pkg::ST_LAST;
                            end
                        end
                        default: begin
                            phase_next  = dbc_pkg::PH_FINAL;
                            status_next = dbc_pkg::ST_LAST;
                        end
                    endcase
                end
            end
            res_next.status   = status_next;
            res_next.finished = (status_next != dbc_pkg::ST_RUN);
        end

        // Register write: restart from the reset state with the new values
        if (cfg_hit) begin
            if (cfg_index == dbc_pkg::CFG_BODY_MODE) begin
                body_mode_next = cfg_wdata[0];
            end else begin
                body_length_next = dbc_pkg::LENGTH_W'(cfg_wdata);
            end
            seen_next   = 1'b0;
            status_next = dbc_pkg::ST_RUN;
            if (body_mode_next) begin
                phase_next = dbc_pkg::PH_HEX;
                chunk_next = '0;
            end else begin
                phase_next = dbc_pkg::PH_FIXED;
                chunk_next = dbc_pkg::CNT_W'(body_length_next);
            end
        end

        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_mode_reg   <= 1'b1;
            body_length_reg <= '0;
            phase_reg       <= dbc_pkg::PH_HEX;
            chunk_reg       <= '0;
            seen_reg        <= 1'b0;
            status_reg      <= dbc_pkg::ST_RUN;
            out_valid_reg   <= 1'b0;
        end else begin
            body_mode_reg   <= body_mode_next;
            body_length_reg <= body_length_next;
            phase_reg       <= phase_next;
            chunk_reg       <= chunk_next;
            seen_reg        <= seen_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_res_reg <= res_next;
        end
    end

    `DBC_ASSERT_IMP(a_final_matches_status, 1'b1, ((phase_reg == dbc_pkg::PH_FINAL) == (status_reg != dbc_pkg::ST_RUN)), "final phase and status disagree")
    `DBC_ASSERT_NXT(a_final_sticks, (phase_reg == dbc_pkg::PH_FINAL) && !cfg_hit, (phase_reg == dbc_pkg::PH_FINAL), "left final phase without a register write")
    `DBC_ASSERT_IMP(a_byte_only_when_ok, out_valid_reg && out_res_reg.body_valid, (out_res_reg.status == dbc_pkg::ST_RUN || out_res_reg.status == dbc_pkg::ST_DONE), "payload byte with an error status")

endmodule

>>> bench/dechunk_checker.sv
// ----------------------------------------------------------------------------
// dechunk_checker
// Watches the input, result and register ports of the HTTP body dechunker,
// decodes every accepted input word on its own and compares each result word
// with the oldest decoded expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dechunk_checker
    import dbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic [4:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    words_checked,
    output int                    payload_bytes,
    output logic [7:0]            status_mask
);

    // decoder copy
    logic        cfg_chunked;
    logic [31:0] cfg_length;
    phase_t      ph;
    logic [63:0] remaining;
    logic        hex_seen;
    status_t     final_st;

    result_t     decoded_q[$];

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void restart_decoder();
        hex_seen = 1'b0;
        final_st = ST_RUN;
        if (cfg_chunked) begin
            ph        = PH_HEX;
            remaining = '0;
        end else begin
            ph        = PH_FIXED;
            remaining = {32'd0, cfg_length};
        end
    endfunction

    function automatic void conclude(input status_t st);
        final_st = st;
        ph       = PH_FINAL;
    endfunction

    function automatic result_t decode_byte(input logic [7:0] c, input logic eos);
        result_t r;
        int      nib;
        r = '0;
        if (ph == PH_FIXED && remaining == 0) conclude(ST_DONE);
        if (ph != PH_FINAL) begin
            if (eos) begin
                if (ph == PH_LAST_END) conclude(ST_DONE);
                else if (ph == PH_LAST_CR || ph == PH_LAST_LF) conclude(ST_LAST);
                else conclude(ST_TRUNC);
            end else begin
                case (ph)
                    PH_FIXED: begin
                        r.body_byte  = c;
                        r.body_valid = 1'b1;
                        remaining    = remaining - 64'd1;
                        if (remaining == 0) conclude(ST_DONE);
                    end
                    PH_HEX: begin
                        nib = hex_nibble(c);
                        if (nib >= 0) begin
                            // leading zeros never reach the top nibble
                            if ((remaining >> (SIZE_BITS - 4)) != 0) begin
                                conclude(ST_OVF);
                            end else begin
                                remaining = (remaining << 4) | 64'(nib);
                                hex_seen  = 1'b1;
                            end
                        end else if (!hex_seen) begin
                            conclude(ST_HEX);
                        end else if (c == CHAR_CR) begin
                            ph = PH_SIZE_LF;
                        end else begin
                            conclude(ST_CRLF);
                        end
                    end
                    PH_SIZE_LF: begin
                        if (c != CHAR_LF) conclude(ST_CRLF);
                        else ph = (remaining == 0) ? PH_LAST_CR : PH_DATA;
                    end
                    PH_DATA: begin
                        r.body_byte  = c;
                        r.body_valid = 1'b1;
                        remaining    = remaining - 64'd1;
                        if (remaining == 0) ph = PH_DATA_CR;
                    end
                    PH_DATA_CR: begin
                        if (c == CHAR_CR) ph = PH_DATA_LF;
                        else conclude(ST_CRLF);
                    end
                    PH_DATA_LF: begin
                        if (c == CHAR_LF) begin
                            ph        = PH_HEX;
                            hex_seen  = 1'b0;
                            remaining = '0;
                        end else begin
                            conclude(ST_CRLF);
                        end
                    end
                    PH_LAST_CR: begin
                        if (c == CHAR_CR) ph = PH_LAST_LF;
                        else conclude(ST_LAST);
                    end
                    PH_LAST_LF: begin
                        if (c == CHAR_LF) ph = PH_LAST_END;
                        else conclude(ST_LAST);
                    end
                    default: conclude(ST_LAST);
                endcase
            end
        end
        r.status   = final_st;
        r.finished = (final_st != ST_RUN);
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        words_checked = 0;
        payload_bytes = 0;
        status_mask   = '0;
    end

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg_chunked = 1'b1;
            cfg_length  = '0;
            restart_decoder();
            decoded_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    note_mismatch($sformatf("result word %0d with nothing pending: byte %02h user %05b",
                                            words_checked, m_tdata, m_tuser));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.body_byte || m_tuser[0] !== want.body_valid ||
                        m_tuser[3:1] !== want.status || m_tuser[4] !== want.finished) begin
                        note_mismatch($sformatf(
                            "word %0d expected byte %02h valid %0b status %0d fin %0b, got byte %02h valid %0b status %0d fin %0b",
                            words_checked, want.body_byte, want.body_valid, want.status,
                            want.finished, m_tdata, m_tuser[0], m_tuser[3:1], m_tuser[4]));
                    end
                    if (want.body_valid) payload_bytes++;
                    status_mask[want.status] = 1'b1;
                end
                words_checked++;
            end
            if (cfg_we) begin
                // unknown indexes leave the decoder alone
                if (cfg_index == CFG_BODY_MODE) begin
                    cfg_chunked = cfg_wdata[0];
                    restart_decoder();
                end else if (cfg_index == CFG_BODY_LENGTH) begin
                    cfg_length = cfg_wdata[31:0];
                    restart_decoder();
                end
            end
            if (s_tvalid && s_tready) decoded_q.push_back(decode_byte(s_tdata, s_tlast));
        end
        outstanding = decoded_q.size();
    end

endmodule

>>> bench/http_body_dechunker_core_tb.sv
// ----------------------------------------------------------------------------
// http_body_dechunker_core_tb
// Drives body words into the dechunker in fixed-length and chunked mode:
// a short directed pass over the corner cases, then random messages that are
// mostly well formed with damaged, truncated and noisy ones mixed in. Both
// handshake sides idle at random; a side checker predicts every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module http_body_dechunker_core_tb;
    import dbc_pkg::*;

    localparam int TOTAL_WORDS  = 1100;
    localparam int DRAIN_CYCLES = 6;       // settling margin after the last result word
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = CFG_IDX_W'(3);

    localparam logic [7:0] ASC_0  = 8'h30;
    localparam logic [7:0] ASC_LA = 8'h61;
    localparam logic [7:0] ASC_UA = 8'h41;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;     // [7:0] data_byte
    logic                  s_tlast;     // stream_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;     // [7:0] body_byte
    logic [4:0]            m_tuser;     // [0] body_valid, [3:1] status, [4] finished
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int         mismatches;
    int         outstanding;
    int         words_checked;
    int         payload_bytes;
    logic [7:0] status_mask;

    int   words_sent = 0;
    int   reg_writes = 0;
    int   cycle_count = 0;
    int   hold_req = 0;
    bit   tx_eager = 0;

    // message under construction: one byte and one end flag per word
    logic [7:0] msg_bytes[$];
    bit         msg_ends[$];

    http_body_dechunker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dechunk_checker body_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .payload_bytes (payload_bytes),
        .status_mask   (status_mask)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
                     outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Message building: all zero-time, fills msg_bytes / msg_ends.
    // ------------------------------------------------------------------------
    task automatic add_word(input logic [7:0] b, input bit e);
        msg_bytes.push_back(b);
        msg_ends.push_back(e);
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_word(b, 1'b0);
    endtask

    // The byte riding with the end marker is ignored, so make it random.
    task automatic add_end();
        add_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_crlf();
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endtask

    // Mix upper and lower case letters for the hex size.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return ASC_0 + 8'(nib);
        return (($urandom_range(0, 1) != 0) ? ASC_UA : ASC_LA) + 8'(nib) - 8'd10;
    endfunction

    task automatic add_hex(input logic [31:0] value, input int zeros);
        int nd;
        nd = 1;
        while (nd < 8 && (value >> (4 * nd)) != 0) nd++;
        repeat (zeros) add_byte(ASC_0);
        for (int i = nd - 1; i >= 0; i--) add_byte(hex_char(value[4*i +: 4]));
    endtask

    // Zero to three data chunks, then the zero-size chunk and end of stream.
    task automatic build_chunked();
        int chunks;
        int sz;
        chunks = $urandom_range(0, 3);
        repeat (chunks) begin
            sz = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 48);
            add_hex(sz, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
            add_crlf();
            repeat (sz) add_byte(8'($urandom_range(0, 255)));
            add_crlf();
        end
        add_hex(0, $urandom_range(0, 1));
        add_crlf();
        add_crlf();
        add_end();
    endtask

    // ------------------------------------------------------------------------
    // Port activity
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_index = idx;
        cfg_wdata = val;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        reg_writes++;
    endtask

    // Mode write with junk in the unused bits; sometimes a stray length or
    // unknown-index write along with it.
    task automatic select_mode(input bit chunked);
        logic [31:0] v;
        if ($urandom_range(0, 9) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
        v    = $urandom;
        v[0] = chunked;
        write_reg(CFG_BODY_MODE, v);
        if (chunked && $urandom_range(0, 2) == 0) write_reg(CFG_BODY_LENGTH, $urandom);
    endtask

    // Offer one word after a random gap and hold it until it is taken.
    // Leaves valid high so a back-to-back word follows without a bubble.
    task automatic send_word(input logic [7:0] b, input bit e);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = b;
        s_tlast  = e;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic play_message();
        tx_eager = ($urandom_range(0, 3) == 0);
        while (msg_bytes.size() != 0) send_word(msg_bytes.pop_front(), msg_ends.pop_front());
    endtask

    // Drop valid and wait until every predicted result word has come out;
    // registers may only be touched after this.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall per word, eager stretches, and the long
    // hold-off on request (counted here, not by the sender).
    // ------------------------------------------------------------------------
    initial begin
        int pause;
        int run_left;
        bit rx_eager;
        m_tready = 1'b0;
        run_left = 0;
        rx_eager = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req > 0) begin
                m_tready = 1'b0;
                repeat (hold_req) @(negedge aclk);
                hold_req = 0;
            end
            if (run_left == 0) begin
                rx_eager = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            pause = rx_eager ? 0 : $urandom_range(0, 14);
            if (pause > 0) begin
                m_tready = 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        int          msg_no;
        int          pick;
        int          sub;
        int          idx;
        int          cut;
        int          len;
        logic [31:0] v;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // --- directed ---
        // Out of reset (chunked): a non-hex first byte is bad hex, then held.
        add_byte(8'h00);
        add_byte(8'hFF);
        play_message();

        // Fixed, zero length: done on the first word with no payload.
        drain();
        write_reg(CFG_BODY_MODE, 32'h0);
        write_reg(CFG_BODY_LENGTH, 32'h0);
        add_byte(8'hFF);
        play_message();

        // Fixed, one byte: passed and done together; a late end is ignored.
        drain();
        write_reg(CFG_BODY_LENGTH, 32'd1);
        add_byte(8'h00);
        add_end();
        play_message();

        // Widest fixed length cut short: truncated.
        drain();
        write_reg(CFG_BODY_LENGTH, 32'hFFFF_FFFF);
        add_byte(8'hA5);
        add_end();
        play_message();

        // One clean chunked body (mode write with every bit set).
        drain();
        write_reg(CFG_BODY_MODE, 32'hFFFF_FFFF);
        add_hex(1, 0);
        add_crlf();
        add_byte(8'hFF);
        add_crlf();
        add_hex(0, 0);
        add_crlf();
        add_crlf();
        add_end();
        play_message();

        // Unknown index must not restart: done is still held.
        drain();
        write_reg(CFG_UNUSED_A, $urandom);
        add_byte(8'h5A);
        play_message();

        // End of stream before the closing CR LF: bad last chunk.
        drain();
        write_reg(CFG_BODY_MODE, 32'h1);
        add_hex(0, 0);
        add_crlf();
        add_end();
        play_message();

        // Digit followed by something other than CR: expect crlf.
        drain();
        write_reg(CFG_BODY_MODE, 32'h1);
        add_byte(ASC_LA);
        add_byte(8'h78);
        play_message();

        // --- random messages ---
        msg_no = 0;
        while (words_sent < TOTAL_WORDS) begin
            drain();
            pick = $urandom_range(0, 99);
            if (msg_no == 3) begin
                // Hold the result side off while a long body streams in, so
                // the queue fills and s_tready drops.
                write_reg(CFG_BODY_MODE, 32'h0);
                write_reg(CFG_BODY_LENGTH, 32'd48);
                repeat (48) add_byte(8'($urandom_range(0, 255)));
                hold_req = HOLD_CYCLES;
            end else if (pick < 62) begin
                select_mode(1'b1);
                build_chunked();
                sub = $urandom_range(0, 9);
                if (sub >= 6 && sub < 9) begin
                    // damage one word somewhere before the final end marker
                    idx = $urandom_range(0, msg_bytes.size() - 2);
                    case ($urandom_range(0, 3))
                        0:       msg_bytes[idx] = 8'($urandom_range(0, 255));
                        1:       msg_bytes[idx] = CHAR_CR;
                        2:       msg_bytes[idx] = CHAR_LF;
                        default: msg_ends[idx]  = 1'b1;
                    endcase
                end else if (sub == 9) begin
                    // cut the stream short
                    cut = $urandom_range(1, msg_bytes.size() - 1);
                    while (msg_bytes.size() > cut) begin
                        void'(msg_bytes.pop_back());
                        void'(msg_ends.pop_back());
                    end
                    add_end();
                end
                repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
            end else if (pick < 69) begin
                select_mode(1'b1);
                case ($urandom_range(0, 2))
                    0: begin
                        // nine significant digits: overflow on the ninth
                        add_byte(hex_char(4'($urandom_range(1, 15))));
                        repeat (8) add_byte(hex_char(4'($urandom_range(0, 15))));
                        add_crlf();
                    end
                    1: begin
                        // long runs of leading zeros are harmless
                        len = $urandom_range(1, 6);
                        add_hex(len, $urandom_range(8, 12));
                        add_crlf();
                        repeat (len) add_byte(8'($urandom_range(0, 255)));
                        add_crlf();
                        add_hex(0, $urandom_range(8, 12));
                        add_crlf();
                        add_crlf();
                        add_end();
                    end
                    default: begin
                        // widest size that fits, then cut off
                        add_hex(32'hFFFF_FFFF, 0);
                        add_crlf();
                        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
                        add_end();
                    end
                endcase
            end else if (pick < 87) begin
                select_mode(1'b0);
                len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
                write_reg(CFG_BODY_LENGTH, len);
                if (len > 0 && $urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(0, len - 1)) add_byte(8'($urandom_range(0, 255)));
                    add_end();
                end else begin
                    repeat (len) add_byte(8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) != 0) add_end();
                end
            end else if (pick < 95) begin
                select_mode(1'b0);
                v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom;
                write_reg(CFG_BODY_LENGTH, v);
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
                add_end();
            end else begin
                // noise: random bytes with scattered end markers
                sub = $urandom_range(0, 1);
                select_mode(sub[0]);
                if (sub == 0) write_reg(CFG_BODY_LENGTH, $urandom_range(0, 12));
                repeat ($urandom_range(5, 20))
                    add_word(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
            end
            play_message();
            msg_no++;
        end

        drain();
        $display("Sent %0d input words in %0d messages with %0d register writes.",
                 words_sent, msg_no + 8, reg_writes);
        $display("Checked %0d result words, %0d payload bytes; status codes seen: %07b.",
                 words_checked, payload_bytes, status_mask[6:0]);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
